FILE: rtl/jsud_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsud_pkg
// Types, codes and helper functions for the JSON string unescape decoder.
// ----------------------------------------------------------------------------
package jsud_pkg;

  // result status codes
  localparam logic [2:0] ST_DATA          = 3'd0;
  localparam logic [2:0] ST_CLOSED        = 3'd1;
  localparam logic [2:0] ST_CONTROL       = 3'd2;
  localparam logic [2:0] ST_BAD_ESCAPE    = 3'd3;
  localparam logic [2:0] ST_BAD_HEX       = 3'd4;
  localparam logic [2:0] ST_BAD_SURROGATE = 3'd5;
  localparam logic [2:0] ST_BAD_UTF8      = 3'd6;
  localparam logic [2:0] ST_TRUNCATED     = 3'd7;

  // characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // code point limits
  localparam logic [20:0] CP_HI_SURR   = 21'h00d800;
  localparam logic [20:0] CP_LO_SURR   = 21'h00dc00;
  localparam logic [20:0] CP_SURR_END  = 21'h00dfff;
  localparam logic [20:0] CP_TWO_BYTE  = 21'h000080;
  localparam logic [20:0] CP_THREE_MIN = 21'h000800;
  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
  localparam logic [20:0] CP_MAX       = 21'h10ffff;

  localparam int unsigned MAX_RESULTS = 4;

  typedef enum logic [7:0] {
    M_NORMAL      = 8'b0000_0001,
    M_ESC         = 8'b0000_0010,
    M_HEX_FIRST   = 8'b0000_0100,
    M_WANT_BSLASH = 8'b0000_1000,
    M_WANT_U      = 8'b0001_0000,
    M_HEX_LOW     = 8'b0010_0000,
    M_UTF8        = 8'b0100_0000,
    M_CLOSED      = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_req;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
  } utf8_enc_t;

  // hex digit value, bit 4 set when not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      v = {1'b0, b[3:0] + 4'd9};
    end
    return v;
  endfunction

  function automatic utf8_enc_t utf8_encode(input logic [20:0] cp);
    utf8_enc_t e;
    e = '0;
    if (cp < CP_TWO_BYTE) begin
      e.cnt      = 3'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp < CP_THREE_MIN) begin
      e.cnt      = 3'd2;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < CP_SUPP_BASE) begin
      e.cnt      = 3'd3;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.cnt      = 3'd4;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/json_string_unescape_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_decoder_top
// Decodes a JSON string body byte by byte into checked UTF-8 output bytes.
// ----------------------------------------------------------------------------
// One source byte enters per item on the byte channel; decoded bytes and status
// codes leave one per item on the res channel. An item is held in an input
// register, decoded combinationally into a four-entry result buffer, and the
// buffer drains one result per cycle while res_ready is high, so plain text
// streams at one byte per clock under the same condition. A byte that completes
// a multi-byte character or escape yields up to four results; the next byte is
// not decoded until the buffer has drained to its last result, so the byte
// channel stalls once the input register is full. The first result reaches the
// output through the input register and then the result buffer. The input
// register takes one more byte while a result is stalled at the output.
module json_string_unescape_decoder_top (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      byte_valid,
  output logic                     byte_ready,
  input  wire jsud_pkg::in_item_t  byte_item,
  output logic                     res_valid,
  input  wire                      res_ready,
  output jsud_pkg::out_item_t      res_item
);

  // input register
  jsud_pkg::in_item_t in_q;
  logic               in_q_valid;

  // decoder state
  jsud_pkg::mode_t mode, mode_next;
  logic [20:0]     acc, acc_next;
  logic [9:0]      hs, hs_next;
  logic [1:0]      rem, rem_next;
  logic [2:0]      seq_len, seq_len_next;
  logic            err, err_next;

  // result buffer, head at entry 0
  jsud_pkg::out_item_t res_buf [jsud_pkg::MAX_RESULTS];
  jsud_pkg::out_item_t res_new [jsud_pkg::MAX_RESULTS];
  logic [2:0]          res_cnt;
  logic [2:0]          n_res;

  logic pop, process;

  assign res_valid = (res_cnt != 3'd0);
  assign res_item  = res_buf[0];
  assign pop       = res_valid && res_ready;
  assign process   = in_q_valid && ((res_cnt == 3'd0) || (res_cnt == 3'd1 && pop));
  assign byte_ready = !in_q_valid || process;

  // decode
  always_comb begin
    jsud_pkg::mode_t    m;
    logic               e;
    logic [7:0]         b;
    logic [4:0]         d;
    logic [15:0]        acc16;
    logic [20:0]        acc21;
    logic [20:0]        cp;
    logic               do_emit;
    logic               do_fail;
    logic               do_close;
    logic [2:0]         fstat;
    jsud_pkg::utf8_enc_t enc;

    b        = in_q.in_byte;
    m        = in_q.start_req ? jsud_pkg::M_NORMAL : mode;
    e        = in_q.start_req ? 1'b0 : err;
    mode_next    = m;
    err_next     = e;
    acc_next     = in_q.start_req ? 21'd0 : acc;
    hs_next      = in_q.start_req ? 10'd0 : hs;
    rem_next     = in_q.start_req ? 2'd0 : rem;
    seq_len_next = in_q.start_req ? 3'd0 : seq_len;
    d        = jsud_pkg::hex_value(b);
    acc16    = {acc_next[11:0], d[3:0]};
    acc21    = {acc_next[14:0], b[5:0]};
    cp       = '0;
    do_emit  = 1'b0;
    do_fail  = 1'b0;
    do_close = 1'b0;
    fstat    = jsud_pkg::ST_DATA;
    n_res    = 3'd0;

    if (!(e || m == jsud_pkg::M_CLOSED)) begin
      if (in_q.end_of_input) begin
        do_fail = 1'b1;
        fstat   = jsud_pkg::ST_TRUNCATED;
      end else begin
        case (m)
          jsud_pkg::M_NORMAL: begin
            if (b == jsud_pkg::CH_QUOTE) begin
              do_close = 1'b1;
            end else if (b == jsud_pkg::CH_BSLASH) begin
              mode_next = jsud_pkg::M_ESC;
            end else if (b < jsud_pkg::CH_SPACE) begin
              do_fail = 1'b1;
              fstat   = jsud_pkg::ST_CONTROL;
            end else if (b < 8'h80) begin
              do_emit = 1'b1;
              cp      = {13'd0, b};
            end else if (b >= 8'hc2 && b <= 8'hdf) begin
              acc_next     = {16'd0, b[4:0]};
              seq_len_next = 3'd2;
              rem_next     = 2'd1;
              mode_next    = jsud_pkg::M_UTF8;
            end else if (b >= 8'he0 && b <= 8'hef) begin
              acc_next     = {17'd0, b[3:0]};
              seq_len_next = 3'd3;
              rem_next     = 2'd2;
              mode_next    = jsud_pkg::M_UTF8;
            end else if (b >= 8'hf0 && b <= 8'hf4) begin
              acc_next     = {18'd0, b[2:0]};
              seq_len_next = 3'd4;
              rem_next     = 2'd3;
              mode_next    = jsud_pkg::M_UTF8;
            end else begin
              do_fail = 1'b1;
              fstat   = jsud_pkg::ST_BAD_UTF8;
            end
          end
          jsud_pkg::M_ESC: begin
            if (b == jsud_pkg::CH_QUOTE || b == jsud_pkg::CH_BSLASH ||
                b == jsud_pkg::CH_SLASH) begin
              do_emit = 1'b1;
              cp      = {13'd0, b};
            end else if (b == jsud_pkg::CH_B) begin
              do_emit = 1'b1;
              cp      = 21'h08;
            end else if (b == jsud_pkg::CH_F) begin
              do_emit = 1'b1;
              cp      = 21'h0c;
            end else if (b == jsud_pkg::CH_N) begin
              do_emit = 1'b1;
              cp      = 21'h0a;
            end else if (b == jsud_pkg::CH_R) begin
              do_emit = 1'b1;
              cp      = 21'h0d;
            end else if (b == jsud_pkg::CH_T) begin
              do_emit = 1'b1;
              cp      = 21'h09;
            end else if (b == jsud_pkg::CH_U) begin
              acc_next  = '0;
              rem_next  = 2'd3;
              mode_next = jsud_pkg::M_HEX_FIRST;
            end else begin
              do_fail = 1'b1;
              fstat   = jsud_pkg::ST_BAD_ESCAPE;
            end
          end
          jsud_pkg::M_HEX_FIRST, jsud_pkg::M_HEX_LOW: begin
            if (d[4]) begin
              do_fail = 1'b1;
              fstat   = jsud_pkg::ST_BAD_HEX;
            end else begin
              acc_next = {5'd0, acc16};
              if (rem_next != 2'd0) begin
                rem_next = rem_next - 2'd1;
              end else if (m == jsud_pkg::M_HEX_FIRST) begin
                if ({5'd0, acc16} >= jsud_pkg::CP_HI_SURR &&
                    {5'd0, acc16} < jsud_pkg::CP_LO_SURR) begin
                  hs_next   = acc16[9:0];
                  mode_next = jsud_pkg::M_WANT_BSLASH;
                end else if ({5'd0, acc16} >= jsud_pkg::CP_LO_SURR &&
                             {5'd0, acc16} <= jsud_pkg::CP_SURR_END) begin
                  do_fail = 1'b1;
                  fstat   = jsud_pkg::ST_BAD_SURROGATE;
                end else begin
                  do_emit = 1'b1;
                  cp      = {5'd0, acc16};
                end
              end else begin
                if ({5'd0, acc16} < jsud_pkg::CP_LO_SURR ||
                    {5'd0, acc16} > jsud_pkg::CP_SURR_END) begin
                  do_fail = 1'b1;
                  fstat   = jsud_pkg::ST_BAD_SURROGATE;
                end else begin
                  do_emit = 1'b1;
                  cp      = jsud_pkg::CP_SUPP_BASE + {1'b0, hs_next, acc16[9:0]};
                end
              end
            end
          end
          jsud_pkg::M_WANT_BSLASH: begin
            if (b != jsud_pkg::CH_BSLASH) begin
              do_fail = 1'b1;
              fstat   = jsud_pkg::ST_BAD_SURROGATE;
            end else begin
              mode_next = jsud_pkg::M_WANT_U;
            end
          end
          jsud_pkg::M_WANT_U: begin
            if (b != jsud_pkg::CH_U) begin
              do_fail = 1'b1;
              fstat   = jsud_pkg::ST_BAD_SURROGATE;
            end else begin
              acc_next  = '0;
              rem_next  = 2'd3;
              mode_next = jsud_pkg::M_HEX_LOW;
            end
          end
          jsud_pkg::M_UTF8: begin
            if (b[7:6] != 2'b10) begin
              do_fail = 1'b1;
              fstat   = jsud_pkg::ST_BAD_UTF8;
            end else begin
              acc_next = acc21;
              if (rem_next > 2'd1) begin
                rem_next = rem_next - 2'd1;
              end else begin
                rem_next = 2'd0;
                // overlong, surrogate and out-of-range checks
                if ((seq_len_next == 3'd3 && acc21 < jsud_pkg::CP_THREE_MIN) ||
                    (seq_len_next == 3'd4 && acc21 < jsud_pkg::CP_SUPP_BASE) ||
                    (acc21 >= jsud_pkg::CP_HI_SURR && acc21 <= jsud_pkg::CP_SURR_END) ||
                    acc21 > jsud_pkg::CP_MAX) begin
                  do_fail = 1'b1;
                  fstat   = jsud_pkg::ST_BAD_UTF8;
                end else begin
                  do_emit = 1'b1;
                  cp      = acc21;
                end
              end
            end
          end
          default: begin
            mode_next = jsud_pkg::M_NORMAL;
          end
        endcase
      end
    end

    enc = jsud_pkg::utf8_encode(cp);
    for (int i = 0; i < jsud_pkg::MAX_RESULTS; i++) begin
      res_new[i] = '0;
    end

    if (do_fail) begin
      err_next   = 1'b1;
      mode_next  = jsud_pkg::M_NORMAL;
      n_res      = 3'd1;
      res_new[0] = '{out_byte: 8'd0, has_byte: 1'b0, status: fstat, last: 1'b1};
    end else if (do_close) begin
      mode_next  = jsud_pkg::M_CLOSED;
      n_res      = 3'd1;
      res_new[0] = '{out_byte: 8'd0, has_byte: 1'b0, status: jsud_pkg::ST_CLOSED,
                     last: 1'b1};
    end else if (do_emit) begin
      mode_next = jsud_pkg::M_NORMAL;
      n_res     = enc.cnt;
      for (int i = 0; i < jsud_pkg::MAX_RESULTS; i++) begin
        if (3'(i) < enc.cnt) begin
          res_new[i] = '{out_byte: enc.bytes[i], has_byte: 1'b1,
                         status: jsud_pkg::ST_DATA, last: (3'(i) == enc.cnt - 3'd1)};
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      in_q_valid <= 1'b1;
    end else if (process) begin
      in_q_valid <= 1'b0;
    end
    if (byte_valid && byte_ready) begin
      in_q <= byte_item;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= jsud_pkg::M_NORMAL;
      err     <= 1'b0;
      acc     <= '0;
      hs      <= '0;
      rem     <= '0;
      seq_len <= '0;
    end else if (process) begin
      mode    <= mode_next;
      err     <= err_next;
      acc     <= acc_next;
      hs      <= hs_next;
      rem     <= rem_next;
      seq_len <= seq_len_next;
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 3'd0;
    end else if (process) begin
      res_cnt <= n_res;
    end else if (pop) begin
      res_cnt <= res_cnt - 3'd1;
    end
    if (process) begin
      for (int i = 0; i < jsud_pkg::MAX_RESULTS; i++) begin
        res_buf[i] <= res_new[i];
      end
    end else if (pop) begin
      for (int i = 0; i < jsud_pkg::MAX_RESULTS - 1; i++) begin
        res_buf[i] <= res_buf[i + 1];
      end
      res_buf[jsud_pkg::MAX_RESULTS - 1] <= '0;
    end
  end

`ifndef ASSERT_OFF
  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= 3'(jsud_pkg::MAX_RESULTS))
    else $error("result buffer count out of range");

  a_last_at_tail: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.last |-> res_cnt == 3'd1)
    else $error("last result is not at the buffer tail");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_item.has_byte |-> res_item.last && res_item.out_byte == 8'd0)
    else $error("status result not alone");

  a_data_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.has_byte |-> res_item.status == jsud_pkg::ST_DATA)
    else $error("data result with nonzero status");

  a_held_item: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !process |=> in_q_valid && $stable(in_q))
    else $error("held item lost before decode");
`endif

endmodule
`default_nettype wire
